// ===== rtl/idea_pkg.sv =====
// Package for the IDEA block cipher: subkey and pipeline types, register
// indexes, stage kinds and the modular arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package idea_pkg;

    localparam int SubkeyCount = 52;
    localparam int HalfRounds  = 17;
    localparam int StageCount  = 25;
    localparam int InvCount    = 18;
    localparam int InvSteps    = 31;

    typedef logic [SubkeyCount-1:0][15:0] subkeys_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH = 2'd0,
        REG_KEY_LOW  = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        STAGE_EVEN    = 2'd0,
        STAGE_ODD_MUL = 2'd1,
        STAGE_ODD_MIX = 2'd2
    } stage_kind_t;

    typedef enum logic {
        KS_IDLE = 1'b0,
        KS_RUN  = 1'b1
    } ks_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ks_status_t;

    typedef struct packed {
        logic [0:3][15:0] w;
        logic [15:0]      t;
        logic             dec;
    } stage_t;

    // Multiplication modulo 65537 where a zero operand stands for 2^16.
    function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        logic [15:0] hi;
        logic [15:0] lo;
        p  = {16'd0, a} * {16'd0, b};
        hi = p[31:16];
        lo = p[15:0];
        if (a == 16'd0)
            return 16'd1 - b;
        else if (b == 16'd0)
            return 16'd1 - a;
        else
            return lo - hi + {15'd0, (lo < hi)};
    endfunction

    // Encryption subkeys: eight words per 25-bit rotation, then words 49 and 50 swap.
    function automatic subkeys_t expand_key(input logic [127:0] key);
        subkeys_t    ek;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        int          base;
        int          j;
        ek = '0;
        for (int i = 0; i < 8; i++)
            ek[i] = key[127-16*i -: 16];
        for (int i = 8; i < SubkeyCount; i++) begin
            j     = i - 7;
            base  = ((i / 8) - 1) * 8;
            a     = ek[base + (j % 8)];
            b     = ek[base + ((j + 1) % 8)];
            ek[i] = {a[6:0], b[15:7]};
        end
        t      = ek[49];
        ek[49] = ek[50];
        ek[50] = t;
        return ek;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/idea_if.sv =====
// Channel interfaces for the IDEA block cipher: input blocks and result blocks.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface idea_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_block;
    logic        decrypt;
    modport source (output valid, output data_block, output decrypt, input ready);
    modport sink (input valid, input data_block, input decrypt, output ready);
endinterface

interface idea_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_block;
    modport source (output valid, output result_block, input ready);
    modport sink (input valid, input result_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/idea_block_cipher_top.sv =====
// Throughput: one 64-bit block per cycle once the subkeys are ready and while the output accepts results.
// Reset and every key register write start the decryption subkey build:
// 18 modular inverses, computed one after another, with input held off.
// Reset is asynchronous and active low; it loads the all-zero key.
`timescale 1ns / 1ps
`default_nettype none
module idea_block_cipher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    idea_in_if.sink          din,
    idea_out_if.source       dout,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    // The key schedule holds the two key registers. The encryption subkeys are
    // pure wiring from them; the decryption subkeys are registers that a small
    // sequencer fills by raising each multiplicative key to the power 65535.
    idea_pkg::subkeys_t   enc_keys;
    idea_pkg::subkeys_t   dec_keys;
    idea_pkg::ks_status_t ks_status;

    idea_ks u_ks (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .enc_keys  (enc_keys),
        .dec_keys  (dec_keys),
        .status    (ks_status)
    );

    // The datapath is a chain of 25 stages with per-stage handshakes, so a
    // stalled output only stops the stages that are full behind it and
    // bubbles collapse. Even half-rounds take one stage each; odd half-rounds
    // take two, one for each of their chained modular multiplications.
    logic                          chain_valid [idea_pkg::StageCount+1];
    logic                          chain_ready [idea_pkg::StageCount+1];
    idea_pkg::stage_t              chain_data  [idea_pkg::StageCount+1];

    // Blocks are held off while the subkeys are being rebuilt.
    assign chain_valid[0]   = din.valid && !ks_status.busy;
    assign din.ready        = chain_ready[0] && !ks_status.busy;
    assign chain_data[0].w   = din.data_block;
    assign chain_data[0].t   = '0;
    assign chain_data[0].dec = din.decrypt;

    assign dout.valid        = chain_valid[idea_pkg::StageCount];
    assign chain_ready[idea_pkg::StageCount] = dout.ready;
    assign dout.result_block = chain_data[idea_pkg::StageCount].w;

    // Half-round h uses subkeys 3h through 3h+3; its first stage sits at
    // h + h/2, counting one extra stage for each odd half-round before it.
    for (genvar h = 0; h < idea_pkg::HalfRounds; h++)
    begin : g_half
        localparam int S = h + h / 2;
        logic [3:0][15:0] ek;
        logic [3:0][15:0] dk;

        for (genvar n = 0; n < 4; n++)
        begin : g_key
            assign ek[n] = enc_keys[3*h+n];
            assign dk[n] = dec_keys[3*h+n];
        end

        if (h % 2 == 0)
        begin : g_even
            idea_stage #(.KIND(idea_pkg::STAGE_EVEN)) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[S]),
                .in_ready  (chain_ready[S]),
                .in_data   (chain_data[S]),
                .enc_keys  (ek),
                .dec_keys  (dk),
                .out_valid (chain_valid[S+1]),
                .out_ready (chain_ready[S+1]),
                .out_data  (chain_data[S+1])
            );
        end
        else
        begin : g_odd
            idea_stage #(.KIND(idea_pkg::STAGE_ODD_MUL)) u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[S]),
                .in_ready  (chain_ready[S]),
                .in_data   (chain_data[S]),
                .enc_keys  (ek),
                .dec_keys  (dk),
                .out_valid (chain_valid[S+1]),
                .out_ready (chain_ready[S+1]),
                .out_data  (chain_data[S+1])
            );
            idea_stage #(.KIND(idea_pkg::STAGE_ODD_MIX)) u_mix (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[S+1]),
                .in_ready  (chain_ready[S+1]),
                .in_data   (chain_data[S+1]),
                .enc_keys  (ek),
                .dec_keys  (dk),
                .out_valid (chain_valid[S+2]),
                .out_ready (chain_ready[S+2]),
                .out_data  (chain_data[S+2])
            );
        end
    end

`ifndef SYNTHESIS
    // No block may enter while the subkeys are being rebuilt.
    a_no_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |-> !ks_status.busy)
        else $error("input transfer during key schedule");

    // A key register write always starts a rebuild.
    a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == idea_pkg::REG_KEY_HIGH
                 || cfg_index == idea_pkg::REG_KEY_LOW)) |=> ks_status.busy)
        else $error("key write did not start key schedule");

    // The last inverse ends the rebuild and releases the input.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ks_status.done |=> !ks_status.busy)
        else $error("key schedule stayed busy after completion");
`endif

endmodule
`default_nettype wire

// ===== rtl/idea_ks.sv =====
// IDEA key schedule: key registers, encryption subkey wiring and a sequenced
// Fermat inverse unit that builds the decryption subkeys. Uses idea_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idea_ks (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    output idea_pkg::subkeys_t       enc_keys,
    output idea_pkg::subkeys_t       dec_keys,
    output idea_pkg::ks_status_t     status
);

    idea_pkg::ks_state_t state_reg, state_next;
    logic [63:0]         key_high_reg;
    logic [63:0]         key_low_reg;
    logic [4:0]          inv_idx_reg;
    logic [4:0]          step_reg;
    logic [15:0]         acc_reg;
    idea_pkg::subkeys_t  dec_reg;
    logic                start;
    logic                step_last;
    logic                inv_last;
    logic [3:0]          pair;
    logic [5:0]          src_idx;
    logic [5:0]          dst_idx;
    logic [15:0]         src;
    logic [15:0]         mul_a;
    logic [15:0]         mul_b;
    logic [15:0]         mul_res;

    assign enc_keys = idea_pkg::expand_key({key_high_reg, key_low_reg});
    assign dec_keys = dec_reg;

    assign start = cfg_we && (cfg_index == idea_pkg::REG_KEY_HIGH
                           || cfg_index == idea_pkg::REG_KEY_LOW);
    assign step_last = (step_reg == 5'(idea_pkg::InvSteps - 1));
    assign inv_last  = (inv_idx_reg == 5'(idea_pkg::InvCount - 1));

    // Inverse j reads subkey 48-6m (even j) or 51-6m (odd j), m = j/2, and lands
    // at decryption slot 6m or 6m+3.
    assign pair    = inv_idx_reg[4:1];
    assign dst_idx = 6'({2'd0, pair} * 6'd6) + (inv_idx_reg[0] ? 6'd3 : 6'd0);
    assign src_idx = 6'd48 - 6'({2'd0, pair} * 6'd6) + (inv_idx_reg[0] ? 6'd3 : 6'd0);
    assign src     = enc_keys[src_idx];

    // a^65535 = a^-1 mod 65537: fifteen rounds of square then multiply by a.
    assign mul_a   = acc_reg;
    assign mul_b   = step_reg[0] ? acc_reg : src;
    assign mul_res = idea_pkg::mul_mod(mul_a, mul_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::KS_IDLE:
            begin
                if (start)
                    state_next = idea_pkg::KS_RUN;
            end
            idea_pkg::KS_RUN:
            begin
                if (!start && step_last && inv_last)
                    state_next = idea_pkg::KS_IDLE;
            end
            default: state_next = idea_pkg::KS_RUN;
        endcase
    end

    always_comb
    begin
        status.busy = (state_reg == idea_pkg::KS_RUN);
        status.done = (state_reg == idea_pkg::KS_RUN) && !start && step_last && inv_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= idea_pkg::KS_RUN;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            inv_idx_reg  <= '0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == idea_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg_data;
            if (cfg_we && cfg_index == idea_pkg::REG_KEY_LOW)
                key_low_reg <= cfg_data;
            if (start)
            begin
                inv_idx_reg <= '0;
                step_reg    <= '0;
            end
            else if (state_reg == idea_pkg::KS_RUN)
            begin
                if (step_last)
                begin
                    step_reg    <= '0;
                    inv_idx_reg <= inv_last ? 5'd0 : inv_idx_reg + 5'd1;
                end
                else
                begin
                    step_reg <= step_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == 5'd0)
            acc_reg <= src;
        else
            acc_reg <= mul_res;
        if (state_reg == idea_pkg::KS_RUN && !start && step_last)
        begin
            dec_reg[dst_idx] <= mul_res;
            if (inv_last)
            begin
                for (int m = 0; m < 9; m++)
                begin
                    dec_reg[6*m+1] <= 16'd0 - enc_keys[50-6*m];
                    dec_reg[6*m+2] <= 16'd0 - enc_keys[49-6*m];
                    if (m < 8)
                    begin
                        dec_reg[6*m+4] <= enc_keys[46-6*m];
                        dec_reg[6*m+5] <= enc_keys[47-6*m];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/idea_stage.sv =====
// One register stage of the IDEA datapath: an even half-round, or one of the
// two halves of an odd half-round. Uses idea_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idea_stage #(
    parameter idea_pkg::stage_kind_t KIND = idea_pkg::STAGE_EVEN
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire idea_pkg::stage_t in_data,
    input  wire logic [3:0][15:0] enc_keys,
    input  wire logic [3:0][15:0] dec_keys,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output idea_pkg::stage_t      out_data
);

    logic             valid_reg;
    idea_pkg::stage_t data_reg;
    idea_pkg::stage_t data_next;
    logic [3:0][15:0] k;
    logic [15:0]      y;
    logic [15:0]      z;

    assign k         = in_data.dec ? dec_keys : enc_keys;
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        y = '0;
        z = '0;
        case (KIND)
            idea_pkg::STAGE_EVEN:
            begin
                data_next.w[0] = idea_pkg::mul_mod(in_data.w[0], k[0]);
                data_next.w[1] = in_data.w[2] + k[2];
                data_next.w[2] = in_data.w[1] + k[1];
                data_next.w[3] = idea_pkg::mul_mod(in_data.w[3], k[3]);
            end
            idea_pkg::STAGE_ODD_MUL:
            begin
                data_next.t = idea_pkg::mul_mod(k[1], in_data.w[0] ^ in_data.w[1]);
            end
            idea_pkg::STAGE_ODD_MIX:
            begin
                y = idea_pkg::mul_mod(in_data.t + (in_data.w[2] ^ in_data.w[3]), k[2]);
                z = in_data.t + y;
                data_next.w[0] = in_data.w[0] ^ y;
                data_next.w[1] = in_data.w[1] ^ y;
                data_next.w[2] = in_data.w[2] ^ z;
                data_next.w[3] = in_data.w[3] ^ z;
            end
            default: data_next = in_data;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire
